@@ rtl/assert_macros.svh @@
// Assertion macros for the execute block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, cond, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

@@ rtl/rv32x_pkg.sv @@
package rv32x_pkg;

    localparam int RegCount = 32;
    localparam int RegIdxW  = 5;

    localparam logic [5:0] OP_ADD = 6'd0, OP_SUB = 6'd1, OP_MUL = 6'd2, OP_DIV = 6'd3,
        OP_SLL = 6'd4, OP_MULH = 6'd5, OP_SLT = 6'd6, OP_MULHSU = 6'd7, OP_SLTU = 6'd8,
        OP_MULHU = 6'd9, OP_XOR = 6'd10, OP_DIVU = 6'd11, OP_SRL = 6'd12, OP_SRA = 6'd13,
        OP_OR = 6'd14, OP_REM = 6'd15, OP_AND = 6'd16, OP_REMU = 6'd17,
        OP_ADDI = 6'd18, OP_SUBI = 6'd19, OP_MULI = 6'd20, OP_DIVI = 6'd21,
        OP_SLLI = 6'd22, OP_SLTI = 6'd23, OP_SLTIU = 6'd24, OP_XORI = 6'd25,
        OP_ORI = 6'd26, OP_ANDI = 6'd27, OP_LOAD = 6'd28, OP_STORE = 6'd29,
        OP_BEQ = 6'd30, OP_BNE = 6'd31, OP_BLT = 6'd32, OP_BGE = 6'd33,
        OP_BLTU = 6'd34, OP_BGEU = 6'd35, OP_JAL = 6'd36, OP_JALR = 6'd37,
        OP_LUI = 6'd38, OP_AUIPC = 6'd39, OP_LDRET = 6'd40;

    localparam logic [1:0] MEM_NONE = 2'd0, MEM_LOAD = 2'd1, MEM_STORE = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_READ, ST_EXEC, ST_ITER, ST_DONE
    } state_t;

    // control from sequencer to the shared unit
    typedef struct packed {
        logic       start;
        logic [5:0] op;
    } unit_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    function automatic logic [5:0] imm_to_alu(input logic [5:0] op);
        logic [5:0] r;
        unique case (op)
            OP_ADDI:  r = OP_ADD;
            OP_SUBI:  r = OP_SUB;
            OP_MULI:  r = OP_MUL;
            OP_DIVI:  r = OP_DIV;
            OP_SLLI:  r = OP_SLL;
            OP_SLTI:  r = OP_SLT;
            OP_SLTIU: r = OP_SLTU;
            OP_XORI:  r = OP_XOR;
            OP_ORI:   r = OP_OR;
            default:  r = OP_AND;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/rv32x_alu.sv @@
// Shared arithmetic unit: registered simple ops, shift-add multiply and
// restoring divide one bit per cycle.
module rv32x_alu
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  rv32x_pkg::unit_ctrl_t  ctrl,
    input  logic [31:0]            a,
    input  logic [31:0]            b,
    output rv32x_pkg::unit_stat_t  stat,
    output logic [31:0]            result
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [5:0]  op_reg, op_next;
    logic [63:0] acc_reg, acc_next;     // product or {remainder, quotient}
    logic [63:0] mcand_reg, mcand_next;
    logic [31:0] mplier_reg, mplier_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        neg_q_reg, neg_q_next, neg_r_reg, neg_r_next;
    logic [31:0] res_reg, res_next;
    logic        is_mul, is_div, a_neg, b_neg;
    logic [31:0] a_abs, b_abs;
    logic [32:0] trial;
    logic [31:0] q, r;
    logic [63:0] p_neg;

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = res_reg;

    always_comb
    begin
        is_mul = (ctrl.op == rv32x_pkg::OP_MUL) || (ctrl.op == rv32x_pkg::OP_MULH)
              || (ctrl.op == rv32x_pkg::OP_MULHSU) || (ctrl.op == rv32x_pkg::OP_MULHU);
        is_div = (ctrl.op == rv32x_pkg::OP_DIV) || (ctrl.op == rv32x_pkg::OP_DIVU)
              || (ctrl.op == rv32x_pkg::OP_REM) || (ctrl.op == rv32x_pkg::OP_REMU);
        a_neg = a[31] && ((ctrl.op == rv32x_pkg::OP_MULH) || (ctrl.op == rv32x_pkg::OP_MULHSU)
              || (ctrl.op == rv32x_pkg::OP_DIV) || (ctrl.op == rv32x_pkg::OP_REM));
        b_neg = b[31] && ((ctrl.op == rv32x_pkg::OP_MULH) || (ctrl.op == rv32x_pkg::OP_DIV)
              || (ctrl.op == rv32x_pkg::OP_REM));
        a_abs = a_neg ? -a : a;
        b_abs = b_neg ? -b : b;

        busy_next = busy_reg; done_next = 1'b0; cnt_next = cnt_reg; op_next = op_reg;
        acc_next = acc_reg; mcand_next = mcand_reg; mplier_next = mplier_reg;
        dvs_next = dvs_reg; neg_q_next = neg_q_reg; neg_r_next = neg_r_reg;
        res_next = res_reg;
        trial = 33'd0; q = '0; r = '0; p_neg = '0;

        if (ctrl.start)
        begin
            op_next = ctrl.op;
            if (is_mul)
            begin
                busy_next = 1'b1; cnt_next = 6'd32; acc_next = '0;
                mcand_next = {32'd0, a_abs}; mplier_next = b_abs;
                neg_q_next = a_neg ^ b_neg;
            end
            else if (is_div && b == 32'd0)
            begin
                res_next = ((ctrl.op == rv32x_pkg::OP_DIV) || (ctrl.op == rv32x_pkg::OP_DIVU))
                    ? 32'hFFFF_FFFF : a;
                done_next = 1'b1;
            end
            else if (is_div)
            begin
                busy_next = 1'b1; cnt_next = 6'd32;
                acc_next = {32'd0, a_abs}; dvs_next = b_abs;
                neg_q_next = a_neg ^ b_neg; neg_r_next = a_neg;
            end
            else
            begin
                done_next = 1'b1;
                case (ctrl.op)
                    rv32x_pkg::OP_ADD:  res_next = a + b;
                    rv32x_pkg::OP_SUB:  res_next = a - b;
                    rv32x_pkg::OP_SLL:  res_next = a << b[4:0];
                    rv32x_pkg::OP_SLT:  res_next = {31'd0, $signed(a) < $signed(b)};
                    rv32x_pkg::OP_SLTU: res_next = {31'd0, a < b};
                    rv32x_pkg::OP_XOR:  res_next = a ^ b;
                    rv32x_pkg::OP_SRL:  res_next = a >> b[4:0];
                    rv32x_pkg::OP_SRA:  res_next = $unsigned($signed(a) >>> b[4:0]);
                    rv32x_pkg::OP_OR:   res_next = a | b;
                    default:            res_next = a & b;
                endcase
            end
        end
        else if (busy_reg)
        begin
            if (op_reg == rv32x_pkg::OP_MUL || op_reg == rv32x_pkg::OP_MULH
                || op_reg == rv32x_pkg::OP_MULHSU || op_reg == rv32x_pkg::OP_MULHU)
            begin
                if (mplier_reg[0])
                    acc_next = acc_reg + mcand_reg;
                mcand_next = {mcand_reg[62:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[31:1]};
            end
            else
            begin
                trial = {acc_reg[63:31]} - {1'b0, dvs_reg};
                if (!trial[32])
                    acc_next = {trial[31:0], acc_reg[30:0], 1'b1};
                else
                    acc_next = {acc_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b0;
            end
        end

        // finish: sign fix and select from the last step's result, in the same cycle
        if (busy_reg && cnt_reg == 6'd1 && !ctrl.start)
        begin
            done_next = 1'b1;
            p_neg = -acc_next;
            if (op_reg == rv32x_pkg::OP_MUL)
            begin
                res_next = neg_q_reg ? -acc_next[31:0] : acc_next[31:0];
            end
            else if (op_reg == rv32x_pkg::OP_MULH || op_reg == rv32x_pkg::OP_MULHSU
                     || op_reg == rv32x_pkg::OP_MULHU)
            begin
                res_next = neg_q_reg ? p_neg[63:32] : acc_next[63:32];
            end
            else
            begin
                q = acc_next[31:0]; r = acc_next[63:32];
                if (op_reg == rv32x_pkg::OP_DIV || op_reg == rv32x_pkg::OP_DIVU)
                    res_next = neg_q_reg ? -q : q;
                else
                    res_next = neg_r_reg ? -r : r;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0; done_reg <= 1'b0; cnt_reg <= '0; op_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next; done_reg <= done_next; cnt_reg <= cnt_next;
            op_reg <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next; mcand_reg <= mcand_next; mplier_reg <= mplier_next;
        dvs_reg <= dvs_next; neg_q_reg <= neg_q_next; neg_r_reg <= neg_r_next;
        res_reg <= res_next;
    end

endmodule

@@ rtl/rv32x_regs.sv @@
// Register file: 32 words, one write and one registered read port; entry
// valid bits stand in for the reset clear.
module rv32x_regs
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        we,
    input  logic [4:0]  waddr,
    input  logic [31:0] wdata,
    input  logic [4:0]  raddr,
    output logic [31:0] rdata
);

    logic [31:0] mem [rv32x_pkg::RegCount];
    logic [rv32x_pkg::RegCount-1:0] vld_reg;
    logic [31:0] rd_reg;
    logic        rvld_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (we)
                vld_reg[waddr] <= 1'b1;
            rvld_reg <= vld_reg[raddr] && (raddr != '0);
        end
    end

    assign rdata = rvld_reg ? rd_reg : 32'd0;

endmodule

@@ rtl/rv32im_execute_regfile.sv @@
// Execute stage of an RV32IM integer core with its own 32-entry register file.
// Memory, branch, jump, upper-immediate and load-return ops pass through the read states
// (src1 then src2 through the read port), execute and result; other ALU ops and divide by
// zero also wait for the shared unit, which for multiply, divide and remainder takes 32 steps.
// One operation at a time: s_tready is low from acceptance until the result is stored.
// Reset clears the halt flag and all register valid bits, so every register reads zero.
module rv32im_execute_regfile
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation[5:0], dest_reg[10:6], src1_reg[15:11], src2_reg[20:16],
    // immediate[52:21], instr_pc[84:53], load_data[116:85], zero fill to 120
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // write_value[31:0], reg_written[32], mem_address[64:33], store_data[96:65],
    // mem_kind[98:97], branch_taken[99], target_pc[131:100], halt[132], fill to 136
    output logic [135:0] m_tdata
);

    rv32x_pkg::state_t state_reg, state_next;
    logic [5:0]  op_reg;
    logic [4:0]  rd_reg;
    logic [4:0]  s1_reg, s2_reg;
    logic [31:0] imm_reg, pc_reg, ld_reg;
    logic [31:0] a_reg, a_next, b_reg, b_next;
    logic        halt_reg, halt_next;
    logic [1:0]  rcnt_reg, rcnt_next;
    logic [135:0] out_reg, out_next;
    logic        ovld_reg, ovld_next;

    logic        rf_we;
    logic [4:0]  rf_raddr;
    logic [31:0] rf_rdata;
    logic [31:0] wv;
    logic        wr_en;
    logic [31:0] addr, sd, tgt;
    logic [1:0]  kind;
    logic        tk, is_alu;
    logic [5:0]  alu_op;
    logic [31:0] alu_b;
    rv32x_pkg::unit_ctrl_t uctrl;
    rv32x_pkg::unit_stat_t ustat;
    logic [31:0] ures;

    rv32x_regs u_regs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (rf_we),
        .waddr (rd_reg),
        .wdata (wv),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    rv32x_alu u_alu
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (uctrl),
        .a      (a_reg),
        .b      (alu_b),
        .stat   (ustat),
        .result (ures)
    );

    // a stored result may wait for its transfer while the next operation enters
    assign s_tready = (state_reg == rv32x_pkg::ST_IDLE);
    assign m_tvalid = ovld_reg;
    assign m_tdata  = out_reg;
    assign is_alu   = op_reg <= rv32x_pkg::OP_ANDI;
    assign alu_op   = (op_reg <= rv32x_pkg::OP_REMU) ? op_reg : rv32x_pkg::imm_to_alu(op_reg);
    assign alu_b    = (op_reg <= rv32x_pkg::OP_REMU) ? b_reg : imm_reg;
    assign rf_raddr = (rcnt_reg == 2'd0) ? s1_reg : s2_reg;

    // result assembly, valid once the unit (if used) is done
    always_comb
    begin
        wv = 32'd0; wr_en = 1'b0; addr = 32'd0; sd = 32'd0; kind = rv32x_pkg::MEM_NONE;
        tk = 1'b0; tgt = 32'd0; halt_next = halt_reg;
        if (is_alu)
        begin
            wv = ures; wr_en = 1'b1;
        end
        else
        begin
            unique case (op_reg)
                rv32x_pkg::OP_LOAD:
                begin
                    addr = a_reg + imm_reg; kind = rv32x_pkg::MEM_LOAD;
                end
                rv32x_pkg::OP_STORE:
                begin
                    addr = a_reg + imm_reg; sd = b_reg; kind = rv32x_pkg::MEM_STORE;
                end
                rv32x_pkg::OP_BEQ:
                begin
                    tk = a_reg == b_reg; tgt = pc_reg + imm_reg;
                end
                rv32x_pkg::OP_BNE:
                begin
                    tk = a_reg != b_reg; tgt = pc_reg + imm_reg;
                end
                rv32x_pkg::OP_BLT:
                begin
                    tk = $signed(a_reg) < $signed(b_reg); tgt = pc_reg + imm_reg;
                end
                rv32x_pkg::OP_BGE:
                begin
                    tk = $signed(a_reg) >= $signed(b_reg); tgt = pc_reg + imm_reg;
                end
                rv32x_pkg::OP_BLTU:
                begin
                    tk = a_reg < b_reg; tgt = pc_reg + imm_reg;
                end
                rv32x_pkg::OP_BGEU:
                begin
                    tk = a_reg >= b_reg; tgt = pc_reg + imm_reg;
                end
                rv32x_pkg::OP_JAL:
                begin
                    tk = 1'b1; tgt = pc_reg + imm_reg; wv = pc_reg + 32'd4; wr_en = 1'b1;
                end
                rv32x_pkg::OP_JALR:  halt_next = 1'b1;
                rv32x_pkg::OP_LUI:
                begin
                    wv = {imm_reg[19:0], 12'd0}; wr_en = 1'b1;
                end
                rv32x_pkg::OP_AUIPC:
                begin
                    wv = pc_reg + {imm_reg[19:0], 12'd0}; wr_en = 1'b1;
                end
                rv32x_pkg::OP_LDRET:
                begin
                    wv = ld_reg; wr_en = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg; rcnt_next = rcnt_reg; a_next = a_reg; b_next = b_reg;
        out_next = out_reg; ovld_next = ovld_reg; rf_we = 1'b0;
        uctrl.start = 1'b0; uctrl.op = alu_op;
        if (ovld_reg && m_tready)
            ovld_next = 1'b0;
        unique case (state_reg)
            rv32x_pkg::ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    state_next = rv32x_pkg::ST_READ; rcnt_next = 2'd0;
                end
            end
            rv32x_pkg::ST_READ:
            begin
                // read src1 then src2 through the single read port
                rcnt_next = rcnt_reg + 2'd1;
                if (rcnt_reg == 2'd1)
                    a_next = rf_rdata;
                if (rcnt_reg == 2'd2)
                begin
                    b_next = rf_rdata; state_next = rv32x_pkg::ST_EXEC;
                end
            end
            rv32x_pkg::ST_EXEC:
            begin
                if (is_alu)
                begin
                    uctrl.start = 1'b1; state_next = rv32x_pkg::ST_ITER;
                end
                else
                begin
                    state_next = rv32x_pkg::ST_DONE;
                end
            end
            rv32x_pkg::ST_ITER:
            begin
                if (ustat.done)
                    state_next = rv32x_pkg::ST_DONE;
            end
            rv32x_pkg::ST_DONE:
            begin
                // hold until the previous result has gone out
                if (!ovld_reg || m_tready)
                begin
                    rf_we = wr_en && (rd_reg != '0);
                    out_next = {3'd0, halt_next, tgt, tk, kind, sd, addr, rf_we, wv};
                    ovld_next = 1'b1;
                    state_next = rv32x_pkg::ST_IDLE;
                end
            end
            default: state_next = rv32x_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rv32x_pkg::ST_IDLE;
            rcnt_reg  <= '0;
            ovld_reg  <= 1'b0;
            halt_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rcnt_reg  <= rcnt_next;
            ovld_reg  <= ovld_next;
            if (state_reg == rv32x_pkg::ST_DONE && state_next == rv32x_pkg::ST_IDLE)
                halt_reg <= halt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg  <= s_tdata[5:0];
            rd_reg  <= s_tdata[10:6];
            s1_reg  <= s_tdata[15:11];
            s2_reg  <= s_tdata[20:16];
            imm_reg <= s_tdata[52:21];
            pc_reg  <= s_tdata[84:53];
            ld_reg  <= s_tdata[116:85];
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        out_reg <= out_next;
    end

`include "assert_macros.svh"

    `ASSERT_IMPLIES(a_no_accept_busy, clk, rst_n, state_reg != rv32x_pkg::ST_IDLE, !s_tready, "busy")
    `ASSERT_NEXT(a_halt_sticky, clk, rst_n, halt_reg, halt_reg, "halt flag cleared")
    `ASSERT_IMPLIES(a_x0_never_written, clk, rst_n, rf_we, rd_reg != 5'd0, "write to register zero")

endmodule

@@ test/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rv32x_pkg::*;

    // One decoded operation as it travels on the slave-side stream
    typedef struct packed {
        logic [5:0]  op;
        logic [4:0]  rd;
        logic [4:0]  rs1;
        logic [4:0]  rs2;
        logic [31:0] imm;
        logic [31:0] pc;
        logic [31:0] ld;
    } exec_op_t;

    // One execute result as it comes back on the master-side stream
    typedef struct packed {
        logic [31:0] wval;
        logic        wr;
        logic [31:0] addr;
        logic [31:0] sdata;
        logic [1:0]  kind;
        logic        taken;
        logic [31:0] target;
        logic        halt;
    } exec_res_t;

    // A row of the directed table; a checked row also compares the predicted
    // result with the value typed in beside it
    typedef struct {
        exec_op_t  item;
        logic      fixed;
        exec_res_t res;
    } exec_row_t;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 60;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // operation[5:0], dest_reg[10:6], src1_reg[15:11], src2_reg[20:16],
    // immediate[52:21], instr_pc[84:53], load_data[116:85], zero fill to 120
    logic [119:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // write_value[31:0], reg_written[32], mem_address[64:33], store_data[96:65],
    // mem_kind[98:97], branch_taken[99], target_pc[131:100], halt[132], fill to 136
    logic [135:0] m_tdata;

    // Predictor state: its own register file and halt flag
    logic [31:0] model_regs [32];
    logic        model_halted;

    exec_res_t   expected_results [$];
    exec_row_t   directed_rows [$];
    int          error_count = 0;
    int          idle_cycles = 0;
    bit          quiet_phase = 1'b0;

    rv32im_execute_regfile uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    function automatic logic [119:0] pack_op(input exec_op_t o);
        return {3'b000, o.ld, o.pc, o.imm, o.rs2, o.rs1, o.rd, o.op};
    endfunction

    function automatic exec_res_t unpack_res(input logic [135:0] d);
        exec_res_t r;
        r.wval   = d[31:0];
        r.wr     = d[32];
        r.addr   = d[64:33];
        r.sdata  = d[96:65];
        r.kind   = d[98:97];
        r.taken  = d[99];
        r.target = d[131:100];
        r.halt   = d[132];
        return r;
    endfunction

    function automatic logic [31:0] read_reg(input logic [4:0] idx);
        return (idx == 5'd0) ? 32'd0 : model_regs[idx];
    endfunction

    // Integer ALU, RISC-V semantics for divide by zero and overflow
    function automatic logic [31:0] alu_result(input logic [5:0] code,
                                               input logic [31:0] a,
                                               input logic [31:0] b);
        logic [63:0] prod;
        logic [4:0]  sh;
        sh = b[4:0];
        case (code)
            OP_ADD:    return a + b;
            OP_SUB:    return a - b;
            OP_MUL:    return a * b;
            OP_DIV:
            begin
                if (b == 0) return '1;
                if (a == 32'h8000_0000 && b == '1) return 32'h8000_0000;
                return $signed(a) / $signed(b);
            end
            OP_SLL:    return a << sh;
            OP_MULH:
            begin
                prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                return prod[63:32];
            end
            OP_SLT:    return {31'd0, $signed(a) < $signed(b)};
            OP_MULHSU:
            begin
                prod = {{32{a[31]}}, a} * {32'd0, b};
                return prod[63:32];
            end
            OP_SLTU:   return {31'd0, a < b};
            OP_MULHU:
            begin
                prod = {32'd0, a} * {32'd0, b};
                return prod[63:32];
            end
            OP_XOR:    return a ^ b;
            OP_DIVU:   return (b == 0) ? '1 : a / b;
            OP_SRL:    return a >> sh;
            OP_SRA:    return $unsigned($signed(a) >>> sh);
            OP_OR:     return a | b;
            OP_REM:
            begin
                if (b == 0) return a;
                if (a == 32'h8000_0000 && b == '1) return 32'd0;
                return $signed(a) % $signed(b);
            end
            OP_AND:    return a & b;
            default:   return (b == 0) ? a : a % b;
        endcase
    endfunction

    function automatic logic [5:0] imm_alu_code(input logic [5:0] op);
        case (op)
            OP_ADDI:  return OP_ADD;
            OP_SUBI:  return OP_SUB;
            OP_MULI:  return OP_MUL;
            OP_DIVI:  return OP_DIV;
            OP_SLLI:  return OP_SLL;
            OP_SLTI:  return OP_SLT;
            OP_SLTIU: return OP_SLTU;
            OP_XORI:  return OP_XOR;
            OP_ORI:   return OP_OR;
            default:  return OP_AND;
        endcase
    endfunction

    // Work out the result of one operation and advance the predictor state
    function automatic exec_res_t execute_op(input exec_op_t o);
        exec_res_t   r;
        logic [31:0] a, b;
        logic        wrt;
        r = '0;
        wrt = 1'b0;
        a = read_reg(o.rs1);
        b = read_reg(o.rs2);
        if (o.op <= OP_REMU)
        begin
            r.wval = alu_result(o.op, a, b);
            wrt = 1'b1;
        end
        else if (o.op <= OP_ANDI)
        begin
            r.wval = alu_result(imm_alu_code(o.op), a, o.imm);
            wrt = 1'b1;
        end
        else if (o.op == OP_LOAD)
        begin
            r.addr = a + o.imm;
            r.kind = MEM_LOAD;
        end
        else if (o.op == OP_STORE)
        begin
            r.addr  = a + o.imm;
            r.sdata = b;
            r.kind  = MEM_STORE;
        end
        else if (o.op <= OP_BGEU)
        begin
            case (o.op)
                OP_BEQ:  r.taken = (a == b);
                OP_BNE:  r.taken = (a != b);
                OP_BLT:  r.taken = ($signed(a) < $signed(b));
                OP_BGE:  r.taken = !($signed(a) < $signed(b));
                OP_BLTU: r.taken = (a < b);
                default: r.taken = (a >= b);
            endcase
            r.target = o.pc + o.imm;
        end
        else if (o.op == OP_JAL)
        begin
            r.taken  = 1'b1;
            r.target = o.pc + o.imm;
            r.wval   = o.pc + 32'd4;
            wrt = 1'b1;
        end
        else if (o.op == OP_JALR)
            model_halted = 1'b1;
        else if (o.op == OP_LUI)
        begin
            r.wval = o.imm << 12;
            wrt = 1'b1;
        end
        else if (o.op == OP_AUIPC)
        begin
            r.wval = o.pc + (o.imm << 12);
            wrt = 1'b1;
        end
        else if (o.op == OP_LDRET)
        begin
            r.wval = o.ld;
            wrt = 1'b1;
        end
        // x0 drops the write but still shows the value
        if (wrt && o.rd != 5'd0)
        begin
            model_regs[o.rd] = r.wval;
            r.wr = 1'b1;
        end
        r.halt = model_halted;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    task automatic compare_result(input exec_res_t got, input exec_res_t want);
        if (got.wval !== want.wval)     report_mismatch("write_value", got.wval, want.wval);
        if (got.wr !== want.wr)         report_mismatch("reg_written", got.wr, want.wr);
        if (got.addr !== want.addr)     report_mismatch("mem_address", got.addr, want.addr);
        if (got.sdata !== want.sdata)   report_mismatch("store_data", got.sdata, want.sdata);
        if (got.kind !== want.kind)     report_mismatch("mem_kind", got.kind, want.kind);
        if (got.taken !== want.taken)
            report_mismatch("branch_taken", got.taken, want.taken);
        if (got.target !== want.target) report_mismatch("target_pc", got.target, want.target);
        if (got.halt !== want.halt)     report_mismatch("halt", got.halt, want.halt);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'h7FFF_FFFF;
            4:       return $urandom_range(0, 40);
            5:       return -$urandom_range(1, 40);
            default: return $urandom;
        endcase
    endfunction

    // Mostly register-file traffic on a few registers so values chain;
    // a little noise with out-of-range operation codes
    function automatic exec_op_t random_op();
        exec_op_t o;
        o.op  = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(41, 63))
                                             : 6'($urandom_range(0, 40));
        if ($urandom_range(0, 3) == 0)
        begin
            o.rd  = 5'($urandom);
            o.rs1 = 5'($urandom);
            o.rs2 = 5'($urandom);
        end
        else
        begin
            o.rd  = 5'($urandom_range(0, 7));
            o.rs1 = 5'($urandom_range(0, 7));
            o.rs2 = 5'($urandom_range(0, 7));
        end
        o.imm = pick_word();
        o.pc  = $urandom;
        o.ld  = pick_word();
        return o;
    endfunction

    function automatic exec_row_t row(input exec_op_t o);
        exec_row_t r;
        r.item  = o;
        r.fixed = 1'b0;
        r.res   = '0;
        return r;
    endfunction

    function automatic exec_row_t row_fixed(input exec_op_t o, input exec_res_t e);
        exec_row_t r;
        r.item  = o;
        r.fixed = 1'b1;
        r.res   = e;
        return r;
    endfunction

    // Present one operation and hold it until the transfer; the predictor
    // runs at the accepting edge so its state follows the block's order
    task automatic send_op(input exec_op_t o, input logic fixed, input exec_res_t want);
        exec_res_t pred;
        while (!quiet_phase && $urandom_range(0, 99) < 37)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= pack_op(o);
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        pred = execute_op(o);
        if (fixed && pred !== want)
            report_mismatch("directed row", pred[31:0], want[31:0]);
        expected_results.push_back(pred);
    endtask

    // Receive side: random stalls, compare each transfer with the oldest
    always @(posedge clk)
    begin
        exec_res_t got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = unpack_res(m_tdata);
                if (expected_results.size() == 0)
                begin
                    error_count++;
                    $display("unexpected result transfer at %0t", $realtime);
                end
                else
                    compare_result(got, expected_results.pop_front());
            end
            m_tready <= quiet_phase ? 1'b1 : ($urandom_range(0, 99) >= 37);
        end
    end

    // Watchdog: count cycles without any transfer
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        exec_op_t  o;
        exec_res_t e;
        for (int i = 0; i < 32; i++)
            model_regs[i] = '0;
        model_halted = 1'b0;

        // Registers read zero after reset: x1 + x2 into x3
        e = '0; e.wr = 1'b1;
        directed_rows.push_back(row_fixed('{OP_ADD, 5'd3, 5'd1, 5'd2, 32'd0, 32'd0, 32'd0}, e));
        // Fill registers with extremes through load_return
        e = '0; e.wval = 32'h8000_0000; e.wr = 1'b1;
        directed_rows.push_back(row_fixed('{OP_LDRET, 5'd1, 5'd0, 5'd0, 32'd0, 32'd0,
                                            32'h8000_0000}, e));
        e = '0; e.wval = 32'hFFFF_FFFF; e.wr = 1'b1;
        directed_rows.push_back(row_fixed('{OP_LDRET, 5'd2, 5'd0, 5'd0, 32'd0, 32'd0,
                                            32'hFFFF_FFFF}, e));
        // x0 drops the write but shows the value
        e = '0; e.wval = 32'h7FFF_FFFF;
        directed_rows.push_back(row_fixed('{OP_LDRET, 5'd0, 5'd0, 5'd0, 32'd0, 32'd0,
                                            32'h7FFF_FFFF}, e));
        directed_rows.push_back(row('{OP_LDRET, 5'd31, 5'd0, 5'd0, 32'd0, 32'd0,
                                      32'h7FFF_FFFF}));
        // Signed overflow in divide and remainder
        e = '0; e.wval = 32'h8000_0000; e.wr = 1'b1;
        directed_rows.push_back(row_fixed('{OP_DIV, 5'd4, 5'd1, 5'd2, 32'd0, 32'd0, 32'd0}, e));
        e = '0; e.wr = 1'b1;
        directed_rows.push_back(row_fixed('{OP_REM, 5'd5, 5'd1, 5'd2, 32'd0, 32'd0, 32'd0}, e));
        // Divide by zero
        e = '0; e.wval = 32'hFFFF_FFFF; e.wr = 1'b1;
        directed_rows.push_back(row_fixed('{OP_DIVU, 5'd6, 5'd1, 5'd0, 32'd0, 32'd0, 32'd0}, e));
        e = '0; e.wval = 32'h8000_0000; e.wr = 1'b1;
        directed_rows.push_back(row_fixed('{OP_REMU, 5'd6, 5'd1, 5'd0, 32'd0, 32'd0, 32'd0}, e));
        directed_rows.push_back(row('{OP_DIVI, 5'd7, 5'd31, 5'd0, 32'd0, 32'd0, 32'd0}));
        directed_rows.push_back(row('{OP_REM, 5'd7, 5'd31, 5'd0, 32'd0, 32'd0, 32'd0}));
        // High products and shifts with amounts above 31
        directed_rows.push_back(row('{OP_MULH, 5'd8, 5'd1, 5'd2, 32'd0, 32'd0, 32'd0}));
        directed_rows.push_back(row('{OP_MULHSU, 5'd9, 5'd1, 5'd2, 32'd0, 32'd0, 32'd0}));
        directed_rows.push_back(row('{OP_MULHU, 5'd10, 5'd2, 5'd2, 32'd0, 32'd0, 32'd0}));
        directed_rows.push_back(row('{OP_SLLI, 5'd11, 5'd2, 5'd0, 32'd33, 32'd0, 32'd0}));
        directed_rows.push_back(row('{OP_SRA, 5'd12, 5'd1, 5'd31, 32'd0, 32'd0, 32'd0}));
        // sltiu against a sign-extended immediate taken as unsigned
        directed_rows.push_back(row('{OP_SLTIU, 5'd13, 5'd31, 5'd0, 32'hFFFF_FFFF, 32'd0, 32'd0}));
        // Memory requests
        directed_rows.push_back(row('{OP_LOAD, 5'd14, 5'd2, 5'd0, 32'd4, 32'd0, 32'd0}));
        directed_rows.push_back(row('{OP_STORE, 5'd14, 5'd1, 5'd2, 32'hFFFF_FFFC, 32'd0, 32'd0}));
        // Branches signed against unsigned, jal link, auipc upper immediate
        directed_rows.push_back(row('{OP_BLT, 5'd0, 5'd1, 5'd31, 32'd16, 32'hFFFF_FFF0, 32'd0}));
        directed_rows.push_back(row('{OP_BGEU, 5'd0, 5'd2, 5'd1, 32'd8, 32'h100, 32'd0}));
        directed_rows.push_back(row('{OP_JAL, 5'd15, 5'd0, 5'd0, 32'h8000_0000, 32'hFFFF_FFFC,
                                      32'd0}));
        directed_rows.push_back(row('{OP_AUIPC, 5'd16, 5'd0, 5'd0, 32'hFFFF_FFFF, 32'h1234, 32'd0}));
        // Jalr sets the sticky halt; an unknown code only reports it
        e = '0; e.halt = 1'b1;
        directed_rows.push_back(row_fixed('{OP_JALR, 5'd17, 5'd1, 5'd2, 32'd0, 32'd0, 32'd0}, e));
        directed_rows.push_back(row_fixed('{6'd63, 5'd18, 5'd1, 5'd2, 32'hFFFF_FFFF,
                                            32'hFFFF_FFFF, 32'hFFFF_FFFF}, e));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_op(directed_rows[i].item, directed_rows[i].fixed, directed_rows[i].res);

        for (int n = 0; n < 2000; n++)
        begin
            // hold a stretch with no idling on either side
            quiet_phase = (n >= 800 && n < 1000);
            o = random_op();
            send_op(o, 1'b0, '0);
        end
        quiet_phase = 1'b0;
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/rv32x_pkg.sv
rtl/rv32x_alu.sv
rtl/rv32x_regs.sv
rtl/rv32im_execute_regfile.sv
test/tb_top.sv
